// File: hw/rtl/fractal_value_noise_3d_core_defines.svh
// ---------------------------------------------------------------------------
// Fractal value noise core - assertion macros
// Shared concurrent assertion forms for the noise pipeline.
// ---------------------------------------------------------------------------
`ifndef FRACTAL_VALUE_NOISE_3D_CORE_DEFINES_SVH
`define FRACTAL_VALUE_NOISE_3D_CORE_DEFINES_SVH

// implication checked every edge outside reset
`define FVN_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// next-cycle implication
`define FVN_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/fvn_pkg.sv
// ---------------------------------------------------------------------------
// Fractal value noise package
// Types, constants and helpers shared by the noise pipeline.
// ---------------------------------------------------------------------------
package fvn_pkg;

    localparam logic [31:0] HASH_KX = 32'h1B873593;
    localparam logic [31:0] HASH_KY = 32'h19088711;
    localparam logic [31:0] HASH_KZ = 32'hB2D05E13;
    localparam logic [31:0] HASH_KM = 32'hCC9E2D51;

    localparam logic [2:0] REG_OCTAVES = 3'd0;
    localparam logic [2:0] REG_GRID    = 3'd1;
    localparam logic [2:0] REG_LINEAR  = 3'd2;
    localparam logic [2:0] REG_SEED0   = 3'd3;
    localparam logic [2:0] REG_SEED1   = 3'd4;
    localparam logic [2:0] REG_SEED2   = 3'd5;
    localparam logic [2:0] REG_SEED3   = 3'd6;

    typedef logic [31:0] t_word;

    // per-octave settings handed to each octave unit
    typedef struct packed {
        logic       active;
        logic [4:0] shift;
        logic       linear;
        t_word      seed;
    } t_oct_cfg;

endpackage

// File: hw/rtl/fvn_weight.sv
// ---------------------------------------------------------------------------
// Fractal value noise - offset weight
// Linear or smoothstep 8-bit-domain weight of one cell offset, 3 stages.
// ---------------------------------------------------------------------------
module fvn_weight (
    input  logic        i_clk,
    input  logic [31:0] i_coord,
    input  logic [4:0]  i_shift,
    input  logic        i_linear,
    output logic [31:0] o_weight
);
    logic [31:0] r_d, n_d;
    logic [4:0]  r_s1, r_s2;
    logic        r_lin1, r_lin2;
    logic [31:0] r_sq;
    logic [33:0] r_k;
    logic [31:0] r_linw;
    logic [31:0] n_t;
    logic [65:0] n_prod;
    logic [31:0] r_w;

    assign n_d = i_coord & ((32'd1 << i_shift) - 32'd1);

    always_ff @(posedge i_clk) begin
        r_d    <= n_d;
        r_s1   <= i_shift;
        r_lin1 <= i_linear;
    end

    always_ff @(posedge i_clk) begin
        r_sq   <= r_d * r_d;
        r_k    <= (34'd3 << r_s1) - {1'b0, r_d, 1'b0};
        r_linw <= (r_d << 8) >> r_s1;
        r_s2   <= r_s1;
        r_lin2 <= r_lin1;
    end

    assign n_t    = (r_sq << 8) >> {r_s2, 1'b0};
    assign n_prod = ({32'd0, r_k} * {34'd0, n_t}) >> r_s2;

    always_ff @(posedge i_clk) begin
        r_w <= r_lin2 ? r_linw : n_prod[31:0];
    end

    assign o_weight = r_w;
endmodule

// File: hw/rtl/fvn_octave.sv
// ---------------------------------------------------------------------------
// Fractal value noise - octave unit
// Hashes eight lattice corners and blends them trilinearly in stages.
// ---------------------------------------------------------------------------
module fvn_octave (
    input  logic             i_clk,
    input  logic [31:0]      i_x,
    input  logic [31:0]      i_y,
    input  logic [31:0]      i_z,
    input  fvn_pkg::t_oct_cfg i_cfg,
    output logic [31:0]      o_value
);
    // stage A: cell indices, partial products
    logic [31:0] r_px0, r_px1, r_py0, r_py1, r_pz0, r_pz1, r_seed;
    logic [31:0] ix, iy, iz;

    assign ix = i_x >> i_cfg.shift;
    assign iy = i_y >> i_cfg.shift;
    assign iz = i_z >> i_cfg.shift;

    always_ff @(posedge i_clk) begin
        r_px0  <= ix * fvn_pkg::HASH_KX;
        r_px1  <= (ix + 32'd1) * fvn_pkg::HASH_KX;
        r_py0  <= iy * fvn_pkg::HASH_KY;
        r_py1  <= (iy + 32'd1) * fvn_pkg::HASH_KY;
        r_pz0  <= iz * fvn_pkg::HASH_KZ;
        r_pz1  <= (iz + 32'd1) * fvn_pkg::HASH_KZ;
        r_seed <= i_cfg.seed;
    end

    // stage B: sum and xorshift; stage C: final multiply
    logic [31:0] r_mix [8];
    logic [31:0] r_c   [8];
    logic [31:0] n_sum [8];

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            n_sum[k] = r_seed + (k[0] ? r_px1 : r_px0) + (k[1] ? r_py1 : r_py0)
                     + (k[2] ? r_pz1 : r_pz0);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) begin
            r_mix[k] <= n_sum[k] ^ (n_sum[k] >> 5);
            r_c[k]   <= r_mix[k] * fvn_pkg::HASH_KM;
        end
    end

    // weights are ready after three stages, as are corners
    logic [31:0] wx, wy, wz;
    logic [31:0] r_wy1, r_wz1, r_wz2;

    fvn_weight u_wx (.i_clk, .i_coord(i_x), .i_shift(i_cfg.shift),
                     .i_linear(i_cfg.linear), .o_weight(wx));
    fvn_weight u_wy (.i_clk, .i_coord(i_y), .i_shift(i_cfg.shift),
                     .i_linear(i_cfg.linear), .o_weight(wy));
    fvn_weight u_wz (.i_clk, .i_coord(i_z), .i_shift(i_cfg.shift),
                     .i_linear(i_cfg.linear), .o_weight(wz));

    function automatic logic [31:0] blend(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] w);
        logic signed [33:0] diff;
        logic signed [66:0] prod;
        diff = $signed({2'b00, b}) - $signed({2'b00, a});
        prod = diff * $signed({1'b0, w});
        return a + prod[39:8];
    endfunction

    logic [31:0] r_e [4];
    logic [31:0] r_f [2];
    logic [31:0] r_v;

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 4; k++) begin
            r_e[k] <= blend(r_c[2*k], r_c[2*k+1], wx);
        end
        r_wy1 <= wy;
        r_wz1 <= wz;
        r_f[0] <= blend(r_e[0], r_e[1], r_wy1);
        r_f[1] <= blend(r_e[2], r_e[3], r_wy1);
        r_wz2 <= r_wz1;
        r_v <= blend(r_f[0], r_f[1], r_wz2);
    end

    assign o_value = r_v;
endmodule

// File: hw/rtl/fractal_value_noise_3d_core.sv
// ---------------------------------------------------------------------------
// Fractal value noise core
// Channel   | signals                               | direction
// input     | i_start/o_busy, i_coord_x/y/z         | in
// config    | i_cfg_valid/o_cfg_ready, index, data  | in
// result    | o_valid, o_noise_value                | out
// One word per cycle; o_valid follows through the 6 octave stages, the weighted-sum
// register and the divide's reciprocal-multiply and output registers.
// o_busy is held low: the pipeline never stalls and the receiver cannot stall.
// Synchronous active-low reset sets the configuration registers to defaults and clears valid bits.
// ---------------------------------------------------------------------------
module fractal_value_noise_3d_core #(
    parameter int MAX_OCTAVES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [31:0] i_coord_z,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_valid,
    output logic [31:0] o_noise_value
);
    `include "fractal_value_noise_3d_core_defines.svh"

    localparam int LAT = 6;

    logic [2:0]  r_oct;
    logic [3:0]  r_grid;
    logic        r_lin;
    logic [31:0] r_seed [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oct  <= 3'd4;
            r_grid <= 4'd8;
            r_lin  <= 1'b0;
            for (int k = 0; k < 4; k++) r_seed[k] <= 32'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fvn_pkg::REG_OCTAVES: r_oct  <= i_cfg_data[2:0];
                fvn_pkg::REG_GRID:    r_grid <= i_cfg_data[3:0];
                fvn_pkg::REG_LINEAR:  r_lin  <= i_cfg_data[0];
                fvn_pkg::REG_SEED0:   r_seed[0] <= i_cfg_data;
                fvn_pkg::REG_SEED1:   r_seed[1] <= i_cfg_data;
                fvn_pkg::REG_SEED2:   r_seed[2] <= i_cfg_data;
                fvn_pkg::REG_SEED3:   r_seed[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_busy      = 1'b0;

    logic [2:0] n_eff;
    logic [3:0] n_top;
    always_comb begin
        n_eff = r_oct;
        if (n_eff < 3'd1) n_eff = 3'd1;
        if (n_eff > 3'(MAX_OCTAVES)) n_eff = 3'(MAX_OCTAVES);
        if (n_eff > 3'd4) n_eff = 3'd4;
        n_top = (r_grid < {1'b0, n_eff}) ? {1'b0, n_eff} : r_grid;
    end

    fvn_pkg::t_oct_cfg n_ocfg [MAX_OCTAVES];
    logic [31:0]       oct_v  [MAX_OCTAVES];

    for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_oct
        always_comb begin
            n_ocfg[g].active = (3'(g) < n_eff);
            n_ocfg[g].shift  = 5'(n_top) - 5'(g);
            n_ocfg[g].linear = r_lin;
            n_ocfg[g].seed   = r_seed[g];
        end
        fvn_octave u_oct (.i_clk, .i_x(i_coord_x), .i_y(i_coord_y), .i_z(i_coord_z),
                          .i_cfg(n_ocfg[g]), .o_value(oct_v[g]));
    end

    // valid and octave count travel alongside the octave units
    logic [LAT-1:0] r_vld;
    logic [2:0]     r_n [LAT];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else          r_vld <= {r_vld[LAT-2:0], i_start};
        r_n[0] <= n_eff;
        for (int k = 1; k < LAT; k++) r_n[k] <= r_n[k-1];
    end

    // weighted sum
    logic [35:0] n_sum;
    always_comb begin
        n_sum = '0;
        for (int k = 0; k < MAX_OCTAVES; k++) begin
            if (3'(k) < r_n[LAT-1])
                n_sum = n_sum + (36'(oct_v[k]) << (r_n[LAT-1] - 3'(k) - 3'd1));
        end
    end

    logic [35:0] r_sum;
    logic [2:0]  r_sn;
    logic        r_sv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sv <= 1'b0;
        else          r_sv <= r_vld[LAT-1];
        r_sum <= n_sum;
        r_sn  <= r_n[LAT-1];
    end

    // divide by 2^n-1: reciprocal multiply, then one correction step
    logic [35:0] n_recip;
    always_comb begin
        case (r_sn)
            3'd2:    n_recip = 36'd22906492245;  // floor(2^36/3)
            3'd3:    n_recip = 36'd9817068105;   // floor(2^36/7)
            3'd4:    n_recip = 36'd4581298449;   // floor(2^36/15)
            default: n_recip = 36'd0;
        endcase
    end

    logic [71:0] r_q;
    logic [35:0] r_dsum;
    logic [2:0]  r_dn;
    logic        r_dv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_dv <= 1'b0;
        else          r_dv <= r_sv;
        r_q    <= r_sum * n_recip;
        r_dsum <= r_sum;
        r_dn   <= r_sn;
    end

    logic [35:0] n_qest, n_rem, n_dvs, n_quo;
    always_comb begin
        n_dvs  = (36'd1 << r_dn) - 36'd1;
        n_qest = r_q[71:36];
        n_rem  = r_dsum - ((n_qest << r_dn) - n_qest);
        n_quo  = (r_dn == 3'd1) ? r_dsum
               : ((n_rem >= n_dvs) ? n_qest + 36'd1 : n_qest);
    end

    logic        r_ov;
    logic [31:0] r_out;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else          r_ov <= r_dv;
        r_out <= n_quo[31:0];
    end

    assign o_valid       = r_ov;
    assign o_noise_value = r_out;

    `FVN_ASSERT_NEXT(a_lat, i_clk, i_rst_n, r_dv, o_valid)
    `FVN_ASSERT_IMP(a_n_range, i_clk, i_rst_n, r_sv, r_sn >= 3'd1 && r_sn <= 3'd4)
    `FVN_ASSERT_IMP(a_busy, i_clk, i_rst_n, 1'b1, !o_busy)
endmodule

// File: tb/fractal_value_noise_3d_core_checker.sv
// ---------------------------------------------------------------------------
// Fractal value noise core - checker
// Tracks register writes and accepted sample points, predicts each noise
// word and compares it with the result channel in order.
// ---------------------------------------------------------------------------
module fractal_value_noise_3d_core_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [31:0] i_coord_x,
    input  logic [31:0] i_coord_y,
    input  logic [31:0] i_coord_z,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    input  logic        i_valid,
    input  logic [31:0] i_noise_value,
    output int          o_pending,
    output int          o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [2:0]     octaves_r;
    logic [3:0]     grid_r;
    logic           linear_r;
    fvn_pkg::t_word seed_r [4];
    fvn_pkg::t_word noise_q [$];
    int             fails = 0;

    assign o_pending    = noise_q.size();
    assign o_fail_count = fails;

    function automatic fvn_pkg::t_word lattice_hash(fvn_pkg::t_word ix, fvn_pkg::t_word iy,
                                                   fvn_pkg::t_word iz, fvn_pkg::t_word seed);
        fvn_pkg::t_word r;
        r = seed + ix * fvn_pkg::HASH_KX + iy * fvn_pkg::HASH_KY + iz * fvn_pkg::HASH_KZ;
        r = r ^ (r >> 5);
        return r * fvn_pkg::HASH_KM;
    endfunction

    function automatic fvn_pkg::t_word cell_weight(fvn_pkg::t_word d, int s);
        fvn_pkg::t_word sq;
        logic [63:0]    t;
        logic [63:0]    k;
        logic [63:0]    p;
        if (linear_r) return (d << 8) >> s;
        sq = d * d;
        t  = {32'd0, sq << 8};
        t  = t >> (2 * s);
        k  = (64'd3 << s) - 2 * {32'd0, d};
        p  = (k * t) >> s;
        return p[31:0];
    endfunction

    function automatic fvn_pkg::t_word mix(fvn_pkg::t_word a, fvn_pkg::t_word b,
                                           fvn_pkg::t_word w);
        logic signed [63:0] p;
        logic signed [63:0] r;
        p = ($signed({32'd0, b}) - $signed({32'd0, a})) * $signed({32'd0, w});
        r = p >>> 8;
        return a + r[31:0];
    endfunction

    function automatic fvn_pkg::t_word octave_value(fvn_pkg::t_word x, fvn_pkg::t_word y,
                                                    fvn_pkg::t_word z, int s,
                                                    fvn_pkg::t_word seed);
        fvn_pkg::t_word mask, ix, iy, iz, wx, wy, wz;
        fvn_pkg::t_word e00, e01, e10, e11, f0, f1;
        mask = (32'd1 << s) - 1;
        ix = x >> s;
        iy = y >> s;
        iz = z >> s;
        wx = cell_weight(x & mask, s);
        wy = cell_weight(y & mask, s);
        wz = cell_weight(z & mask, s);
        e00 = mix(lattice_hash(ix, iy, iz, seed), lattice_hash(ix + 1, iy, iz, seed), wx);
        e01 = mix(lattice_hash(ix, iy + 1, iz, seed),
                  lattice_hash(ix + 1, iy + 1, iz, seed), wx);
        e10 = mix(lattice_hash(ix, iy, iz + 1, seed),
                  lattice_hash(ix + 1, iy, iz + 1, seed), wx);
        e11 = mix(lattice_hash(ix, iy + 1, iz + 1, seed),
                  lattice_hash(ix + 1, iy + 1, iz + 1, seed), wx);
        f0 = mix(e00, e01, wy);
        f1 = mix(e10, e11, wy);
        return mix(f0, f1, wz);
    endfunction

    function automatic fvn_pkg::t_word noise_of(fvn_pkg::t_word x, fvn_pkg::t_word y,
                                                fvn_pkg::t_word z);
        int          n;
        int          top;
        logic [63:0] sum;
        logic [63:0] q;
        n = octaves_r;
        if (n < 1) n = 1;
        if (n > 4) n = 4;
        top = (grid_r < n) ? n : grid_r;
        sum = 0;
        for (int i = 0; i < n; i++)
            sum += {32'd0, octave_value(x, y, z, top - i, seed_r[i])} << (n - 1 - i);
        q = sum / ((64'd1 << n) - 1);
        return q[31:0];
    endfunction

    task automatic report_mismatch(string what, fvn_pkg::t_word got, fvn_pkg::t_word want);
        $display("mismatch: %s got %08h expected %08h", what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            octaves_r <= 3'd4;
            grid_r    <= 4'd8;
            linear_r  <= 1'b0;
            for (int i = 0; i < 4; i++) seed_r[i] <= '0;
            noise_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    fvn_pkg::REG_OCTAVES: octaves_r <= i_cfg_data[2:0];
                    fvn_pkg::REG_GRID:    grid_r    <= i_cfg_data[3:0];
                    fvn_pkg::REG_LINEAR:  linear_r  <= i_cfg_data[0];
                    fvn_pkg::REG_SEED0:   seed_r[0] <= i_cfg_data;
                    fvn_pkg::REG_SEED1:   seed_r[1] <= i_cfg_data;
                    fvn_pkg::REG_SEED2:   seed_r[2] <= i_cfg_data;
                    fvn_pkg::REG_SEED3:   seed_r[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid) begin
                if (noise_q.size() == 0) begin
                    report_mismatch("unexpected word", i_noise_value, '0);
                end else begin
                    fvn_pkg::t_word want;
                    want = noise_q.pop_front();
                    if (i_noise_value !== want)
                        report_mismatch("noise_value", i_noise_value, want);
                end
            end
            if (i_start && !i_busy)
                noise_q.push_back(noise_of(i_coord_x, i_coord_y, i_coord_z));
        end
    end
endmodule

// File: tb/fractal_value_noise_3d_core_test.sv
// ---------------------------------------------------------------------------
// Fractal value noise core - testbench top
// Drives directed and random sample points through several register
// settings with random gaps; the checker predicts and compares.
// ---------------------------------------------------------------------------
module fractal_value_noise_3d_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN       = 24;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] cx, cy, cz;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        res_valid;
    logic [31:0] res_noise;
    int          pending;
    int          fail_count;
    int          cycles = 0;

    fractal_value_noise_3d_core u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_coord_x(cx), .i_coord_y(cy), .i_coord_z(cz),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_valid(res_valid), .o_noise_value(res_noise)
    );

    fractal_value_noise_3d_core_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_coord_x(cx), .i_coord_y(cy), .i_coord_z(cz),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(res_valid), .i_noise_value(res_noise),
        .o_pending(pending), .o_fail_count(fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("fractal_value_noise_3d_core regression: fail");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic fvn_pkg::t_word rand_coord();
        case ($urandom_range(0, 4))
            0:       return $urandom_range(0, 4095);
            1:       return 32'hFFFF_FFFF - $urandom_range(0, 4095);
            2:       return {8'($urandom_range(0, 255)), 24'h0} | 32'($urandom_range(0, 255));
            default: return $urandom;
        endcase
    endfunction

    // valid stays high across consecutive writes; the caller drops it
    task automatic reg_write(logic [2:0] idx, fvn_pkg::t_word data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // one word per call; start stays high across back-to-back words
    task automatic send_point(fvn_pkg::t_word x, fvn_pkg::t_word y, fvn_pkg::t_word z);
        int g;
        start <= 1'b1;
        cx <= x;
        cy <= y;
        cz <= z;
        do @(posedge clk); while (busy);
        g = gap_len();
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic random_points(int count);
        int m;
        for (int k = 0; k < count; k++) begin
            m = $urandom_range(0, 9);
            if (m == 0)      send_point(rand_coord(), 0, 0);
            else if (m == 1) send_point(rand_coord(), rand_coord(), 0);
            else             send_point(rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic apply_setting(int oct, int grid, int lin, fvn_pkg::t_word s0,
                                 fvn_pkg::t_word s1, fvn_pkg::t_word s2,
                                 fvn_pkg::t_word s3);
        reg_write(fvn_pkg::REG_OCTAVES, oct);
        reg_write(fvn_pkg::REG_GRID, grid);
        reg_write(fvn_pkg::REG_LINEAR, lin);
        reg_write(fvn_pkg::REG_SEED0, s0);
        reg_write(fvn_pkg::REG_SEED1, s1);
        reg_write(fvn_pkg::REG_SEED2, s2);
        reg_write(fvn_pkg::REG_SEED3, s3);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial begin
        rst_n     = 1'b0;
        start     = 1'b0;
        cx        = '0;
        cy        = '0;
        cz        = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, edge coordinates, 1D and 2D
        send_point(0, 0, 0);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h0000_00FF, 0, 0);
        send_point(32'h0000_0100, 32'h0000_01FF, 0);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0080);
        send_point(32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FF00);
        settle();

        // octave count zero, grid below octave count, linear
        apply_setting(0, 0, 1, 32'hFFFF_FFFF, 32'h1234_5678, 0, 32'hDEAD_BEEF);
        send_point(0, 0, 0);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_point(32'h0000_0001, 32'h0000_0003, 0);
        settle();
        // saturated octave count, largest cell sizes, smoothstep wrap
        apply_setting(7, 15, 0, 32'h0BAD_F00D, 32'hFFFF_FFFF, 32'h8000_0000, 1);
        send_point(32'h0000_7FFF, 32'h0000_FFFF, 32'hFFFF_7FFF);
        send_point(32'h0001_0000, 32'hFFFF_FFFF, 0);
        send_point(32'h0000_4000, 32'h0000_2000, 32'h0000_1000);
        settle();
        apply_setting(4, 1, 0, 0, 0, 0, 0);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0002);
        send_point(32'h0000_0003, 32'hFFFF_FFFE, 32'h0000_0001);
        settle();

        random_points(80);
        settle();
        for (int ph = 0; ph < 8; ph++) begin
            apply_setting($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 1),
                          $urandom, $urandom, $urandom, $urandom);
            random_points(75);
            settle();
        end
        apply_setting(1, 12, 1, 32'hFFFF_FFFF, 0, 0, 0);
        random_points(30);
        settle();

        if (fail_count == 0)
            $display("fractal_value_noise_3d_core regression: pass");
        else
            $display("fractal_value_noise_3d_core regression: fail");
        $finish;
    end
endmodule
